// File: hw/rtl/atm_pkg.sv
// Shared types and constants for the alarm table matcher.
// Used by the table memory, the controller, the top level and the checker.
// No dependencies.
package atm_pkg;

	localparam int MAX_ENTRIES_DEF = 16;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_MASTER_ENABLE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 1'd1;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// One alarm entry as it sits in the table: enable, weekday mask, hour, minute.
	typedef struct packed {
		logic       en;
		logic [7:0] days;
		logic [4:0] hour;
		logic [5:0] minute;
	} entry_t;

	typedef struct packed {
		logic       master_enable;
		logic [4:0] entry_count;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/atm_if.sv
// Valid/ready channel interfaces for the alarm table matcher.
// Input channel carries load and tick items, output channel carries results.
// No dependencies.
interface atm_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [3:0] entry_index;
	logic       entry_enabled;
	logic [7:0] entry_days;
	logic [4:0] entry_hour;
	logic [5:0] entry_minute;
	logic [4:0] now_hour;
	logic [5:0] now_minute;
	logic [5:0] now_second;
	logic [2:0] now_weekday;
	logic       output_busy;

	modport source (
		output valid, req_type, entry_index, entry_enabled, entry_days, entry_hour,
		       entry_minute, now_hour, now_minute, now_second, now_weekday, output_busy,
		input  ready
	);
	modport sink (
		input  valid, req_type, entry_index, entry_enabled, entry_days, entry_hour,
		       entry_minute, now_hour, now_minute, now_second, now_weekday, output_busy,
		output ready
	);
endinterface

interface atm_out_if;
	logic       valid;
	logic       ready;
	logic       fired;
	logic [3:0] fired_index;

	modport source (output valid, fired, fired_index, input ready);
	modport sink (input valid, fired, fired_index, output ready);
endinterface

// File: hw/rtl/atm_table.sv
// Alarm entry table: single write port, single synchronous read port.
// Read data is registered and appears in the cycle after the read enable.
// Depends on atm_pkg.
module atm_table #(
	parameter int DEPTH = atm_pkg::MAX_ENTRIES_DEF,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  atm_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output atm_pkg::entry_t rdata
);

	atm_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/atm_ctrl.sv
// Item controller: takes items, writes loaded entries, scans the table on a tick,
// tracks the last fired minute and holds the result register.
// Depends on atm_pkg and the channel interfaces.
module atm_ctrl #(
	parameter int MAX_ENTRIES = atm_pkg::MAX_ENTRIES_DEF,
	parameter int AW          = 4,
	parameter int CW          = 5
) (
	input  logic            clk,
	input  logic            arst_n,
	input  atm_pkg::cfg_t   cfg,
	atm_in_if.sink          in_ch,
	atm_out_if.source       out_ch,
	output logic            mem_we,
	output logic [AW-1:0]   mem_waddr,
	output atm_pkg::entry_t mem_wdata,
	output logic            mem_re,
	output logic [AW-1:0]   mem_raddr,
	input  atm_pkg::entry_t mem_rdata
);

	atm_pkg::state_t state_q, state_d;

	logic [CW-1:0] limit_q, limit_d;
	logic [CW-1:0] issue_idx_q, issue_idx_d;
	logic          pend_s1;
	logic [AW-1:0] pend_idx_s1;

	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [2:0] wday_q;

	logic       trk_valid_q, trk_valid_d;
	logic [4:0] trk_hour_q, trk_hour_d;
	logic [5:0] trk_minute_q, trk_minute_d;

	logic       res_fired_q, res_fired_d;
	logic [3:0] res_idx_q, res_idx_d;
	logic       out_valid_q, out_valid_d;
	logic       out_fired_q;
	logic [3:0] out_idx_q;

	logic          accept;
	logic          issue;
	logic          hit;
	logic          same_minute;
	logic [CW-1:0] limit_now;

	assign in_ch.ready     = (state_q == atm_pkg::ST_IDLE);
	assign accept          = in_ch.valid && in_ch.ready;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.fired    = out_fired_q;
	assign out_ch.fired_index = out_idx_q;

	assign limit_now = (32'(cfg.entry_count) > MAX_ENTRIES) ? CW'(MAX_ENTRIES)
	                                                         : CW'(cfg.entry_count);

	// Loads go straight into the table in the transfer cycle.
	assign mem_we    = accept && (in_ch.req_type == atm_pkg::REQ_LOAD) &&
	                   (32'(in_ch.entry_index) < MAX_ENTRIES);
	assign mem_waddr = AW'(in_ch.entry_index);
	assign mem_wdata = '{en: in_ch.entry_enabled, days: in_ch.entry_days,
	                     hour: in_ch.entry_hour, minute: in_ch.entry_minute};

	// One read is issued per scan cycle; its data is compared in the following cycle.
	assign issue     = (state_q == atm_pkg::ST_SCAN) && (issue_idx_q < limit_q);
	assign mem_re    = issue;
	assign mem_raddr = issue_idx_q[AW-1:0];

	assign hit = (state_q == atm_pkg::ST_SCAN) && pend_s1 && mem_rdata.en &&
	             mem_rdata.days[wday_q] && (mem_rdata.hour == hour_q) &&
	             (mem_rdata.minute == minute_q);
	assign same_minute = trk_valid_q && (trk_hour_q == hour_q) && (trk_minute_q == minute_q);

	always_comb begin
		state_d      = state_q;
		limit_d      = limit_q;
		issue_idx_d  = issue_idx_q;
		trk_valid_d  = trk_valid_q;
		trk_hour_d   = trk_hour_q;
		trk_minute_d = trk_minute_q;
		res_fired_d  = res_fired_q;
		res_idx_d    = res_idx_q;
		out_valid_d  = out_valid_q;
		if (out_valid_q && out_ch.ready) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			atm_pkg::ST_IDLE: begin
				if (accept) begin
					res_fired_d = 1'b0;
					res_idx_d   = '0;
					limit_d     = limit_now;
					issue_idx_d = '0;
					state_d     = atm_pkg::ST_DONE;
					if (in_ch.req_type == atm_pkg::REQ_TICK && cfg.master_enable) begin
						if (in_ch.now_second != 6'd0) begin
							// The time has moved off the fired minute, so forget it.
							if (trk_valid_q && (in_ch.now_hour != trk_hour_q ||
							                    in_ch.now_minute != trk_minute_q)) begin
								trk_valid_d  = 1'b0;
								trk_hour_d   = '0;
								trk_minute_d = '0;
							end
						end else if (!in_ch.output_busy && limit_now != '0) begin
							state_d = atm_pkg::ST_SCAN;
						end
					end
				end
			end
			atm_pkg::ST_SCAN: begin
				if (hit) begin
					state_d = atm_pkg::ST_DONE;
					if (!same_minute) begin
						res_fired_d  = 1'b1;
						res_idx_d    = 4'(pend_idx_s1);
						trk_valid_d  = 1'b1;
						trk_hour_d   = hour_q;
						trk_minute_d = minute_q;
					end
				end else if (pend_s1 && !issue) begin
					state_d = atm_pkg::ST_DONE;
				end
				if (issue) begin
					issue_idx_d = issue_idx_q + CW'(1);
				end
			end
			atm_pkg::ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					out_valid_d = 1'b1;
					state_d     = atm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = atm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= atm_pkg::ST_IDLE;
			pend_s1      <= 1'b0;
			trk_valid_q  <= 1'b0;
			trk_hour_q   <= '0;
			trk_minute_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			pend_s1      <= issue;
			trk_valid_q  <= trk_valid_d;
			trk_hour_q   <= trk_hour_d;
			trk_minute_q <= trk_minute_d;
			out_valid_q  <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		limit_q     <= limit_d;
		issue_idx_q <= issue_idx_d;
		pend_idx_s1 <= issue_idx_q[AW-1:0];
		res_fired_q <= res_fired_d;
		res_idx_q   <= res_idx_d;
		if (accept) begin
			hour_q   <= in_ch.now_hour;
			minute_q <= in_ch.now_minute;
			wday_q   <= in_ch.now_weekday;
		end
		if (state_q == atm_pkg::ST_DONE && (!out_valid_q || out_ch.ready)) begin
			out_fired_q <= res_fired_q;
			out_idx_q   <= res_idx_q;
		end
	end

endmodule

// File: hw/rtl/alarm_table_matcher_unit.sv
// Alarm table matcher top level: configuration registers, entry table and controller.
// A load or a non-scanning tick moves to ST_DONE and sets its result once the output is free;
// a scanning tick reads the n entries in use, one table read per cycle, up to the first hit.
// One item is in work at a time; the next is taken once the result sits in the output register.
// Reset clears the last fired minute, sets master_enable to 1 and entry_count to 0;
// table entries hold no reset value and must be loaded before they are scanned.
module alarm_table_matcher_unit #(
	parameter int MAX_ENTRIES = atm_pkg::MAX_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	atm_in_if.sink                         in_ch,
	atm_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [atm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [atm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	atm_pkg::cfg_t   cfg_q;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	atm_pkg::entry_t mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	atm_pkg::entry_t mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_enable <= 1'b1;
			cfg_q.entry_count   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				atm_pkg::CFG_MASTER_ENABLE: cfg_q.master_enable <= cfg_wdata[0];
				atm_pkg::CFG_ENTRY_COUNT:   cfg_q.entry_count   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	atm_table #(
		.DEPTH(MAX_ENTRIES),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	atm_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.AW         (AW),
		.CW         (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

endmodule

// File: hw/rtl/atm_checker.sv
// Port-level checks for the alarm table matcher, attached to the top level by bind.
// Depends on atm_pkg and alarm_table_matcher_unit.
module atm_checker #(
	parameter int MAX_ENTRIES = atm_pkg::MAX_ENTRIES_DEF
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       fired,
	input logic [3:0] fired_index
);

	// A result that has not been taken keeps its valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before its transfer");

	// Only one item is in work: the input closes right after a transfer.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input open while an item is in work");

	// No result can appear in the cycle right after an input transfer.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !(out_valid && !out_ready) |=> !out_valid)
		else $error("result appeared too early");

	// A result that did not fire reports index zero; a fired index lies in the table.
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fired || fired_index == 4'd0) &&
		              (!fired || 32'(fired_index) < MAX_ENTRIES))
		else $error("fired index out of place");

endmodule

bind alarm_table_matcher_unit atm_checker #(
	.MAX_ENTRIES(MAX_ENTRIES)
) u_atm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.fired      (out_ch.fired),
	.fired_index(out_ch.fired_index)
);
